// ===== sv/dmpid_pkg.sv =====
// Shared types and constants for the dual-mode PID controller.
// Holds the beat structs, the configuration struct and the register indexes.
// No dependencies.
package dmpid_pkg;

   // Sample and result widths are fixed by the beat layout.
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int COUNT_W  = 16;
   localparam int DRIVE_W  = 16;

   // Internal datapath widths.
   localparam int ERR_W  = SAMPLE_W + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int DD_W   = ERR_W + 2;
   localparam int PROD_W = GAIN_W + 1 + DD_W;
   localparam int ACC_W  = 32;
   localparam int SUM_W  = 40;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KP              = 3'd0,
      REG_KI_DT           = 3'd1,
      REG_KD_DT           = 3'd2,
      REG_OUTPUT_LIMIT    = 3'd3,
      REG_VELOCITY_MODE   = 3'd4,
      REG_ERROR_TOLERANCE = 3'd5,
      REG_SETTLE_STEPS    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      converged;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   kp;
      logic [GAIN_W-1:0]   ki_dt;
      logic [GAIN_W-1:0]   kd_dt;
      logic [LIMIT_W-1:0]  output_limit;
      logic                velocity_mode;
      logic [SAMPLE_W-1:0] error_tolerance;
      logic [COUNT_W-1:0]  settle_steps;
   } cfg_type;

endpackage

// ===== sv/dmpid_csr.sv =====
// Configuration register file of the dual-mode PID controller.
// Depends on dmpid_pkg for the register indexes and the cfg_type struct.
module dmpid_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [dmpid_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dmpid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output dmpid_pkg::cfg_type                    cfg
);
   import dmpid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_KP:              cfg_in.kp              = csr_wdata;
            REG_KI_DT:           cfg_in.ki_dt           = csr_wdata;
            REG_KD_DT:           cfg_in.kd_dt           = csr_wdata;
            REG_OUTPUT_LIMIT:    cfg_in.output_limit    = csr_wdata[LIMIT_W-1:0];
            REG_VELOCITY_MODE:   cfg_in.velocity_mode   = csr_wdata[0];
            REG_ERROR_TOLERANCE: cfg_in.error_tolerance = csr_wdata;
            REG_SETTLE_STEPS:    cfg_in.settle_steps    = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.output_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/dmpid_datapath.sv =====
// Single-pass PID datapath with controller state and settle counter.
// Depends on dmpid_pkg for the beat and configuration structs.
module dmpid_datapath #(
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  dmpid_pkg::req_type sample,
   input  dmpid_pkg::cfg_type cfg,
   output dmpid_pkg::rsp_type result
);
   import dmpid_pkg::*;

   localparam int F = GAIN_FRACTION_BITS;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'((2 ** F) / 2);
   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(64'sd2147483648);

   logic signed [ACC_W-1:0]  integral_ff, integral_in;
   logic signed [ACC_W-1:0]  vacc_ff, vacc_in;
   logic signed [ERR_W-1:0]  last_err_ff, prev_err_ff;
   logic [COUNT_W-1:0]       settle_cnt_ff, settle_cnt_in;

   logic signed [ERR_W-1:0]  err;
   logic signed [DIFF_W-1:0] d1;
   logic signed [DD_W-1:0]   d2;
   logic signed [DD_W-1:0]   kp_op, kd_op;
   logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
   logic signed [PROD_W-1:0] p_kp, p_ki, p_kd;
   logic signed [SUM_W-1:0]  pd_sum, ilim, i_raw, pos_sum, v_raw, sum, rnd, lim;
   logic [ERR_W-1:0]         err_mag;
   logic                     settled;

   always_comb begin
      err = ERR_W'(sample.target) - ERR_W'(sample.measured);
      d1  = DIFF_W'(err) - DIFF_W'(last_err_ff);
      d2  = DD_W'(err) - (DD_W'(last_err_ff) <<< 1) + DD_W'(prev_err_ff);

      // The kp and kd multipliers are shared by both forms; only the operands move.
      kp_op = cfg.velocity_mode ? DD_W'(d1) : DD_W'(err);
      kd_op = cfg.velocity_mode ? d2 : DD_W'(d1);

      kp_s = $signed({1'b0, cfg.kp});
      ki_s = $signed({1'b0, cfg.ki_dt});
      kd_s = $signed({1'b0, cfg.kd_dt});

      p_kp = kp_s * kp_op;
      p_ki = ki_s * err;
      p_kd = kd_s * kd_op;

      pd_sum = SUM_W'(p_kp) + SUM_W'(p_kd);

      // Positional form: integral saturates at the output limit in Q form.
      ilim  = $signed(SUM_W'(cfg.output_limit) << F);
      i_raw = SUM_W'(integral_ff) + SUM_W'(p_ki);
      if (i_raw > ilim) begin
         integral_in = ACC_W'(ilim);
      end else if (i_raw < -ilim) begin
         integral_in = ACC_W'(-ilim);
      end else begin
         integral_in = ACC_W'(i_raw);
      end
      pos_sum = pd_sum + SUM_W'(integral_in);

      // Velocity form: accumulator saturates at the signed 32-bit bounds.
      v_raw = SUM_W'(vacc_ff) + pd_sum + SUM_W'(p_ki);
      if (v_raw > ACC_MAX) begin
         vacc_in = ACC_W'(ACC_MAX);
      end else if (v_raw < ACC_MIN) begin
         vacc_in = ACC_W'(ACC_MIN);
      end else begin
         vacc_in = ACC_W'(v_raw);
      end

      sum = cfg.velocity_mode ? SUM_W'(vacc_in) : pos_sum;
      rnd = (sum + HALF) >>> F;
      lim = $signed(SUM_W'(cfg.output_limit));
      if (rnd > lim) begin
         result.drive = DRIVE_W'(lim);
      end else if (rnd < -lim) begin
         result.drive = DRIVE_W'(-lim);
      end else begin
         result.drive = DRIVE_W'(rnd);
      end

      err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      settled = (err_mag <= ERR_W'(cfg.error_tolerance));
      if (!settled) begin
         settle_cnt_in = '0;
      end else if (settle_cnt_ff == '1) begin
         settle_cnt_in = settle_cnt_ff;
      end else begin
         settle_cnt_in = settle_cnt_ff + 1'b1;
      end
      result.converged = settled && (settle_cnt_in > cfg.settle_steps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         vacc_ff       <= '0;
         last_err_ff   <= '0;
         prev_err_ff   <= '0;
         settle_cnt_ff <= '0;
      end else if (step_en) begin
         if (cfg.velocity_mode) begin
            vacc_ff <= vacc_in;
         end else begin
            integral_ff <= integral_in;
         end
         prev_err_ff   <= last_err_ff;
         last_err_ff   <= err;
         settle_cnt_ff <= settle_cnt_in;
      end
   end

endmodule

// ===== sv/dual_mode_pid_with_settle_detect.sv =====
// Top level of the dual-mode PID controller with settle detection.
// Depends on dmpid_pkg, dmpid_csr and dmpid_datapath.
//
// Usage:
// Each beat on the req_ channel carries a target and a measured sample.
// For every accepted beat exactly one beat leaves on the rsp_ channel with
// the clamped drive value and the converged flag, in order.
// A beat is accepted at a rising clock edge where valid is high and stall
// is low; the receiver drives stall.
// The req_ beat lands in an input register, the whole PID step is done by
// three parallel multipliers and an adder and clamp network on the way to
// the output register, and from there its result is offered on rsp_.
// Throughput is one beat per cycle while rsp_stall stays low, set by that
// single register-to-register pass that also updates the controller state.
// When rsp_stall is high the result waits in the output register while one
// more beat can still enter the input register; req_stall rises only when
// both registers are full and the output is stalled.
// The csr_ port writes one configuration register per enabled cycle and
// should be used only while no beat is in flight.
// Synchronous reset empties both registers, clears the integral, the
// velocity accumulator, the error history and the settle counter, and loads
// the configuration defaults (output limit 32767, all else zero).
module dual_mode_pid_with_settle_detect #(
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dmpid_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dmpid_pkg::rsp_type                rsp_data,
   input  logic                              csr_write_en,
   input  logic [dmpid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmpid_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dmpid_pkg::*;

   cfg_type cfg;
   rsp_type step_result;

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;

   logic    req_accept;
   logic    advance;
   logic    rsp_taken;

   dmpid_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dmpid_datapath #(
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // The input register moves forward whenever the output register is
   // empty or is being emptied in this cycle.
   assign advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && out_vld_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_taken  = out_vld_ff && !rsp_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_taken) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== sv/dmpid_checker.sv =====
// Port-level checks for the dual-mode PID controller, bound to the top level.
// Depends on dmpid_pkg for the beat structs.
module dmpid_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dmpid_pkg::rsp_type rsp_data
);
   import dmpid_pkg::*;

   localparam logic [DRIVE_W-1:0] DRIVE_MOST_NEG = {1'b1, {(DRIVE_W - 1){1'b0}}};

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // The input side only stalls when the output side is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result side can move");

   // After an accepted beat a result is waiting on the output side.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("no result two cycles after an accepted beat");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed or vanished");

   // The clamp is symmetric, so the most negative code never appears.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.drive != DRIVE_MOST_NEG))
      else $error("drive outside the symmetric clamp range");

endmodule

bind dual_mode_pid_with_settle_detect dmpid_checker u_checker (.*);

// ===== tb/pid_drive_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the dual-mode PID controller: follows the csr_ writes,
// predicts one drive beat per accepted req_ beat and compares it on rsp_.
// Depends on dmpid_pkg.
module pid_drive_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  dmpid_pkg::req_type                req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  dmpid_pkg::rsp_type                rsp_data,
   input  logic                              csr_write_en,
   input  logic [dmpid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmpid_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                beats_outstanding
);
   import dmpid_pkg::*;

   localparam int     FRAC_BITS    = 8;
   localparam longint HALF_LSB     = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint ACC_MAX      = 64'sd2147483647;
   localparam longint ACC_MIN      = -64'sd2147483648;
   localparam int     COUNT_MAX    = 65535;
   localparam int     REPORT_LIMIT = 10;

   cfg_type cfg;
   longint  integ_sum;
   longint  vel_sum;
   longint  err_prev;
   longint  err_prev2;
   int      settled_run;
   rsp_type drive_expected[$];

   function automatic longint saturate(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endfunction

   // One controller step: updates the predicted state and returns the beat.
   function automatic rsp_type next_drive(req_type beat);
      longint  err;
      longint  lim;
      longint  ilim;
      longint  sum;
      longint  step_inc;
      longint  level;
      longint  mag;
      rsp_type result;
      err = longint'($signed(beat.target)) - longint'($signed(beat.measured));
      lim = longint'(cfg.output_limit);
      if (!cfg.velocity_mode) begin
         ilim = lim <<< FRAC_BITS;
         integ_sum = saturate(integ_sum + longint'(cfg.ki_dt) * err, -ilim, ilim);
         sum = longint'(cfg.kp) * err + integ_sum
               + longint'(cfg.kd_dt) * (err - err_prev);
      end else begin
         step_inc = longint'(cfg.kp) * (err - err_prev)
                    + longint'(cfg.ki_dt) * err
                    + longint'(cfg.kd_dt) * (err - 2 * err_prev + err_prev2);
         vel_sum = saturate(vel_sum + step_inc, ACC_MIN, ACC_MAX);
         sum = vel_sum;
      end
      level = saturate((sum + HALF_LSB) >>> FRAC_BITS, -lim, lim);
      err_prev2 = err_prev;
      err_prev = err;
      mag = (err < 0) ? -err : err;
      if (mag <= longint'(cfg.error_tolerance)) begin
         if (settled_run < COUNT_MAX) settled_run++;
         result.converged = (settled_run > int'(cfg.settle_steps));
      end else begin
         settled_run = 0;
         result.converged = 1'b0;
      end
      result.drive = level[DRIVE_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg = '0;
         cfg.output_limit = LIMIT_RESET;
         integ_sum = 0;
         vel_sum = 0;
         err_prev = 0;
         err_prev2 = 0;
         settled_run = 0;
         drive_expected.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_KP:              cfg.kp = csr_wdata;
               REG_KI_DT:           cfg.ki_dt = csr_wdata;
               REG_KD_DT:           cfg.kd_dt = csr_wdata;
               REG_OUTPUT_LIMIT:    cfg.output_limit = csr_wdata[LIMIT_W-1:0];
               REG_VELOCITY_MODE:   cfg.velocity_mode = csr_wdata[0];
               REG_ERROR_TOLERANCE: cfg.error_tolerance = csr_wdata;
               REG_SETTLE_STEPS:    cfg.settle_steps = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_expected.size() == 0) begin
               note_failure($sformatf("rsp beat with none pending: drive %0d conv %0b",
                                      rsp_data.drive, rsp_data.converged));
            end else begin
               want = drive_expected.pop_front();
               if (rsp_data.drive !== want.drive) begin
                  note_failure($sformatf("drive mismatch: expected %0d, got %0d",
                                         want.drive, rsp_data.drive));
               end
               if (rsp_data.converged !== want.converged) begin
                  note_failure($sformatf("converged mismatch: expected %0b, got %0b",
                                         want.converged, rsp_data.converged));
               end
            end
         end
         if (req_valid && !req_stall) begin
            drive_expected.push_back(next_drive(req_data));
         end
      end
      beats_outstanding = drive_expected.size();
   end

endmodule

// ===== tb/dual_mode_pid_with_settle_detect_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the dual-mode PID controller: drives req_ and csr_ beats,
// stalls rsp_ at random and gives the verdict from the checker's counts.
// Depends on dmpid_pkg, pid_drive_checker and the controller RTL.
module dual_mode_pid_with_settle_detect_tb;
   import dmpid_pkg::*;

   // Index 7 has no register behind it; writes there must be dropped.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   localparam int  LONG_HOLD_CYCLES = 60;
   localparam int  SETTLE_RUN_ITEMS = 40;
   localparam int  SEGMENT_ITEMS    = 105;
   localparam int  SEGMENTS         = 4;
   localparam int  IDLE_PHASES      = 4;
   localparam int  END_CYCLES       = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int beats_outstanding;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int stall_pct = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit long_hold_req = 1'b0;
   int hold_left = 0;

   dual_mode_pid_with_settle_detect i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pid_drive_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .beats_outstanding (beats_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver. A long hold-off is counted down here while the sender keeps
   // offering beats, so both pipeline registers fill and req_stall must rise.
   // Otherwise rsp_stall is rolled fresh on every falling edge.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Hard stop in case the handshake hangs. The slowest legal run stays well
   // under a tenth of this.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type beat_of(int target, int measured);
      req_type beat;
      beat.target = 16'(target);
      beat.measured = 16'(measured);
      return beat;
   endfunction

   // Most random beats keep the error small, so the settle counter and the
   // unsaturated part of the output range get exercised. The rest are full
   // range, which flips every input bit and drives the clamps.
   function automatic req_type random_beat();
      req_type           beat;
      logic signed [15:0] offset;
      beat.target = 16'($urandom);
      if ($urandom_range(99) < 60) begin
         offset = 16'($urandom_range(80) - 40);
         beat.measured = beat.target - offset;
      end else begin
         beat.measured = 16'($urandom);
      end
      return beat;
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(3))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1023));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // Offers one beat from a falling edge and returns on the falling edge after
   // it was taken. Valid stays high for a following beat, so the caller lowers
   // it once the burst is over.
   task automatic send_beat(req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Ends a burst and waits until every predicted beat has come back, so the
   // block is idle before the next register write.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (beats_outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Writes all seven registers. Unused upper bits of the limit and mode
   // writes carry noise, which the block must drop, and a stray write to the
   // unused index must change nothing.
   task automatic load_settings(logic [15:0] kp, logic [15:0] ki_dt, logic [15:0] kd_dt,
                                logic [14:0] limit, logic mode, logic [15:0] tolerance,
                                logic [15:0] steps);
      logic [15:0] noise;
      noise = 16'($urandom);
      write_reg(REG_KP, kp);
      write_reg(REG_KI_DT, ki_dt);
      write_reg(REG_KD_DT, kd_dt);
      write_reg(REG_OUTPUT_LIMIT, {noise[15], limit});
      write_reg(REG_VELOCITY_MODE, {noise[14:0], mode});
      write_reg(REG_ERROR_TOLERANCE, tolerance);
      write_reg(REG_SETTLE_STEPS, steps);
      write_reg(REG_UNUSED, 16'($urandom));
      csr_write_en <= 1'b0;
   endtask

   task automatic random_settings();
      logic [14:0] limit;
      logic [15:0] tolerance;
      logic [15:0] steps;
      case ($urandom_range(3))
         0: limit = 15'd0;
         1: limit = 15'h7FFF;
         default: limit = 15'($urandom_range(32767, 1));
      endcase
      case ($urandom_range(3))
         0: tolerance = 16'd0;
         1: tolerance = 16'hFFFF;
         2: tolerance = 16'($urandom_range(64));
         default: tolerance = 16'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
         0: steps = 16'd0;
         3: steps = 16'($urandom_range(65535));
         default: steps = 16'($urandom_range(8));
      endcase
      load_settings(pick_gain(), pick_gain(), pick_gain(), limit, 1'($urandom_range(1)),
                    tolerance, steps);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: all gains zero, so the drive must be zero. An exact
      // match with zero tolerance already counts as settled.
      send_beat(beat_of(1000, -1000));
      send_beat(beat_of(0, 0));
      wait_for_results();

      // Unit proportional gain at both error extremes; the output clamps at
      // the symmetric limit, not at the negative end of the 16-bit range.
      load_settings(16'd256, 16'd0, 16'd0, 15'h7FFF, 1'b0, 16'd0, 16'd0);
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(-32768, 32767));
      send_beat(beat_of(0, 0));
      send_beat(beat_of(5, 0));
      send_beat(beat_of(-5, 0));
      wait_for_results();

      // Half gain: plus one half rounds up to one, minus one half to zero.
      load_settings(16'd128, 16'd0, 16'd0, 15'h7FFF, 1'b0, 16'd0, 16'd0);
      send_beat(beat_of(1, 0));
      send_beat(beat_of(0, 1));
      wait_for_results();

      // Full gains with a small limit: the integral saturates at the limit in
      // both directions. The last beats walk the settle counter past two.
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd1000, 1'b0, 16'd16, 16'd2);
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(-32768, 32767));
      send_beat(beat_of(3, 0));
      send_beat(beat_of(0, 0));
      send_beat(beat_of(1, 1));
      send_beat(beat_of(2, 0));
      send_beat(beat_of(0, 0));
      wait_for_results();

      // A zero limit forces the drive to zero whatever the error.
      load_settings(16'hFFFF, 16'hFFFF, 16'd0, 15'd0, 1'b0, 16'd0, 16'd0);
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(-100, 50));
      wait_for_results();

      // Velocity form at full gains: the 32-bit accumulator saturates at both
      // signed bounds within a step or two.
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1, 16'd0, 16'd0);
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(32767, -32768));
      send_beat(beat_of(-32768, 32767));
      send_beat(beat_of(-32768, 32767));
      wait_for_results();

      // Mode switches: each form resumes from its own stored sum, while the
      // error history keeps moving in both.
      load_settings(16'd256, 16'd16, 16'd32, 15'h7FFF, 1'b0, 16'd0, 16'd0);
      send_beat(beat_of(10, 0));
      send_beat(beat_of(20, 5));
      wait_for_results();
      load_settings(16'd256, 16'd16, 16'd32, 15'h7FFF, 1'b1, 16'd0, 16'd0);
      send_beat(beat_of(-7, 3));
      send_beat(beat_of(40, 0));
      wait_for_results();

      // Settle counter with the widest tolerance: every beat is settled, yet
      // with the largest step count the flag stays low. The count carries
      // over the next register writes, and an out-of-tolerance beat then
      // clears it.
      load_settings(16'd300, 16'd20, 16'd40, 15'd20000, 1'b1, 16'hFFFF, 16'hFFFF);
      repeat (SETTLE_RUN_ITEMS) send_beat(random_beat());
      wait_for_results();
      load_settings(16'd300, 16'd20, 16'd40, 15'd20000, 1'b1, 16'hFFFF, 16'hFFFE);
      repeat (3) send_beat(random_beat());
      wait_for_results();
      load_settings(16'd300, 16'd20, 16'd40, 15'd20000, 1'b1, 16'd0, 16'hFFFE);
      send_beat(beat_of(9, 2));
      wait_for_results();

      // Random part: four handshake phases (no idling, sender idle, receiver
      // stalling, both), each split into segments with fresh settings. The
      // first segment of the phases where the sender never idles opens with
      // a long receiver hold-off to back the pipeline up.
      for (int phase = 0; phase < IDLE_PHASES; phase++) begin
         send_idle_pct = (phase == 1) ? 45 : ((phase == 3) ? 18 : 0);
         stall_pct = (phase == 2) ? 45 : ((phase == 3) ? 18 : 0);
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            random_settings();
            if (seg == 0 && (phase == 0 || phase == 2)) long_hold_req = 1'b1;
            repeat (SEGMENT_ITEMS) send_beat(random_beat());
            wait_for_results();
         end
      end

      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0 && beats_outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
